// File: rtl/gf2qs_pkg.sv
// ----------------------------------------------------------------------------
// gf2qs_pkg: shared types and constants
// Field widths, request codes, controller states and the command and status
// bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package gf2qs_pkg;

	localparam int KEY_ADDR_W = 9;
	localparam int KEY_WORD_W = 64;
	localparam int VAR_W      = 32;
	localparam int EQ_VAL_W   = 32;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EVAL = 1'b1;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_PACK  = 6'b000010,
		ST_FLUSH = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} gf2qs_state_t;

	typedef struct packed {
		logic load;
		logic pack_start;
		logic pack_step;
		logic flush;
		logic walk_start;
		logic walk_step;
		logic out_load;
	} gf2qs_cmd_t;

	typedef struct packed {
		logic pack_last;
		logic walk_last;
	} gf2qs_sts_t;

endpackage

// File: rtl/gf2qs_req_if.sv
// ----------------------------------------------------------------------------
// gf2qs_req_if: request channel
// Valid/ready channel carrying one load or evaluate request.
// ----------------------------------------------------------------------------
interface gf2qs_req_if import gf2qs_pkg::*; ();

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic [KEY_ADDR_W-1:0] key_addr;
	logic [KEY_WORD_W-1:0] key_word;
	logic [VAR_W-1:0]      var_bits;

	modport source (output valid, output cmd, output key_addr, output key_word,
		output var_bits, input ready);
	modport sink (input valid, input cmd, input key_addr, input key_word,
		input var_bits, output ready);

endinterface

// File: rtl/gf2qs_rsp_if.sv
// ----------------------------------------------------------------------------
// gf2qs_rsp_if: response channel
// Valid/ready channel carrying the equation values of one evaluation.
// ----------------------------------------------------------------------------
interface gf2qs_rsp_if import gf2qs_pkg::*; ();

	logic                valid;
	logic                ready;
	logic [EQ_VAL_W-1:0] equation_values;

	modport source (output valid, output equation_values, input ready);
	modport sink (input valid, input equation_values, output ready);

endinterface

// File: rtl/gf2qs_ram.sv
// ----------------------------------------------------------------------------
// gf2qs_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gf2qs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 288,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/gf2qs_dp.sv
// ----------------------------------------------------------------------------
// gf2qs_dp: evaluation datapath
// Key store, monomial packer with its word buffer, and the row walk that
// folds key words against the monomial vector into equation parities.
// ----------------------------------------------------------------------------
module gf2qs_dp import gf2qs_pkg::*; #(
	parameter int NUM_VARS  = 32,
	parameter int NUM_EQS   = 32,
	parameter int ROW_WORDS = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gf2qs_cmd_t            cmd,
	input  logic [KEY_ADDR_W-1:0] key_addr,
	input  logic [KEY_WORD_W-1:0] key_word,
	input  logic [VAR_W-1:0]      var_bits,
	output gf2qs_sts_t            sts,
	output logic [EQ_VAL_W-1:0]   equation_values
);

	localparam int KEY_DEPTH = NUM_EQS * ROW_WORDS;
	localparam int KA_W      = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int VW        = (ROW_WORDS > 1) ? $clog2(ROW_WORDS) : 1;
	localparam int EW        = (NUM_EQS > 1) ? $clog2(NUM_EQS) : 1;
	localparam int IW        = $clog2(NUM_VARS);
	localparam int MONO_BITS = 1 + NUM_VARS * (NUM_VARS + 1) / 2;
	localparam int VEC_WORDS = (MONO_BITS + 63) / 64;
	localparam int WC_W      = $clog2(VEC_WORDS + 1);

	logic [NUM_VARS-1:0] x_q;
	logic [IW-1:0]       i_q;
	logic [127:0]        pbuf_q;
	logic [6:0]          cnt_q;
	logic [WC_W-1:0]     wcnt_q;
	logic [KA_W-1:0]     kaddr_q;
	logic [VW-1:0]       w_q;
	logic [EW-1:0]       e_q;
	logic                valid_s1;
	logic                row_end_s1;
	logic                vzero_s1;
	logic                acc_q;
	logic [NUM_EQS-1:0]  res_q;
	logic [EQ_VAL_W-1:0] eq_q;

	logic [95:0]         var_ext;
	logic [31:0]         key_addr_ext;
	logic                key_we;
	logic [KA_W-1:0]     key_waddr;
	logic [63:0]         key_rdata;
	logic [6:0]          row_len;
	logic [63:0]         row_bits;
	logic [127:0]        merged;
	logic [6:0]          sum_cnt;
	logic                word_full;
	logic [31:0]         wcnt_ext;
	logic                vec_we;
	logic [63:0]         vec_wdata;
	logic [VW-1:0]       vec_waddr;
	logic [63:0]         vec_rdata;
	logic                w_last;
	logic                e_last;
	logic                par;
	logic [NUM_EQS:0]    res_shift;
	logic [95:0]         res_ext;

	assign var_ext      = {64'b0, var_bits};
	assign key_addr_ext = 32'(key_addr);
	assign key_we       = cmd.load && (key_addr_ext < KEY_DEPTH);
	assign key_waddr    = key_addr_ext[KA_W-1:0];

	assign row_len   = 7'(NUM_VARS) - 7'(i_q);
	assign row_bits  = x_q[i_q] ? 64'(x_q >> i_q) : 64'b0;
	assign merged    = pbuf_q | (128'(row_bits) << cnt_q);
	assign sum_cnt   = cnt_q + row_len;
	assign word_full = sum_cnt[6];

	assign wcnt_ext  = 32'(wcnt_q);
	assign vec_we    = ((cmd.pack_step && word_full) || (cmd.flush && (cnt_q != 7'd0)))
		&& (wcnt_ext < ROW_WORDS);
	assign vec_wdata = cmd.flush ? pbuf_q[63:0] : merged[63:0];
	assign vec_waddr = wcnt_ext[VW-1:0];

	assign w_last = (32'(w_q) == ROW_WORDS - 1);
	assign e_last = (32'(e_q) == NUM_EQS - 1);

	assign sts.pack_last = (32'(i_q) == NUM_VARS - 1);
	assign sts.walk_last = w_last && e_last;

	assign par       = (^(key_rdata & vec_rdata)) & ~vzero_s1;
	assign res_shift = {acc_q ^ par, res_q};
	assign res_ext   = 96'(res_q);

	assign equation_values = eq_q;

	gf2qs_ram #(.WIDTH(64), .DEPTH(KEY_DEPTH), .AW(KA_W)) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (key_waddr),
		.wdata (key_word),
		.raddr (kaddr_q),
		.rdata (key_rdata)
	);

	gf2qs_ram #(.WIDTH(64), .DEPTH(ROW_WORDS), .AW(VW)) u_vec_ram (
		.clk   (clk),
		.we    (vec_we),
		.waddr (vec_waddr),
		.wdata (vec_wdata),
		.raddr (w_q),
		.rdata (vec_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			cnt_q    <= '0;
			wcnt_q   <= '0;
			kaddr_q  <= '0;
			w_q      <= '0;
			e_q      <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.pack_start) begin
				i_q    <= '0;
				cnt_q  <= 7'd1;
				wcnt_q <= '0;
			end else if (cmd.pack_step) begin
				i_q <= i_q + 1'b1;
				if (word_full) begin
					cnt_q  <= sum_cnt - 7'd64;
					wcnt_q <= wcnt_q + 1'b1;
				end else begin
					cnt_q <= sum_cnt;
				end
			end
			if (cmd.walk_start) begin
				kaddr_q <= '0;
				w_q     <= '0;
				e_q     <= '0;
			end else if (cmd.walk_step) begin
				kaddr_q <= kaddr_q + 1'b1;
				if (w_last) begin
					w_q <= '0;
					e_q <= e_q + 1'b1;
				end else begin
					w_q <= w_q + 1'b1;
				end
			end
			valid_s1 <= cmd.walk_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pack_start) begin
			x_q    <= var_ext[NUM_VARS-1:0];
			pbuf_q <= 128'd1;
		end else if (cmd.pack_step) begin
			pbuf_q <= word_full ? (merged >> 64) : merged;
		end
		row_end_s1 <= w_last;
		vzero_s1   <= (32'(w_q) >= VEC_WORDS);
		if (cmd.walk_start) begin
			acc_q <= 1'b0;
		end else if (valid_s1) begin
			if (row_end_s1) begin
				res_q <= res_shift[NUM_EQS:1];
				acc_q <= 1'b0;
			end else begin
				acc_q <= acc_q ^ par;
			end
		end
		if (cmd.out_load) begin
			eq_q <= res_ext[EQ_VAL_W-1:0];
		end
	end

	a_cnt_below_word: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < 7'd64)
		else $error("packer fill count reached a full word");

	a_flush_word_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> (wcnt_ext + ((cnt_q != 7'd0) ? 32'd1 : 32'd0)) == VEC_WORDS)
		else $error("monomial vector word count mismatch at flush");

	a_no_load_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_step || valid_s1) |-> !key_we)
		else $error("key store written during row walk");

endmodule

// File: rtl/gf2qs_ctrl.sv
// ----------------------------------------------------------------------------
// gf2qs_ctrl: evaluation controller
// Sequences packing, flush, row walk and result hand-off; owns the request
// and response handshakes.
// ----------------------------------------------------------------------------
module gf2qs_ctrl import gf2qs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic       req_cmd,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	input  gf2qs_sts_t sts,
	output gf2qs_cmd_t cmd
);

	gf2qs_state_t state_q;
	gf2qs_state_t state_d;
	logic         out_valid_q;
	logic         req_fire;
	logic         out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign out_free  = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (req_fire) begin
					if (req_cmd == CMD_EVAL) begin
						cmd.pack_start = 1'b1;
						state_d        = ST_PACK;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_PACK: begin
				cmd.pack_step = 1'b1;
				if (sts.pack_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				cmd.flush      = 1'b1;
				cmd.walk_start = 1'b1;
				state_d        = ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || rsp_ready))
		else $error("pending result overwritten");

	a_pack_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PACK && sts.pack_last) |=> (state_q == ST_FLUSH))
		else $error("packer end not followed by flush");

endmodule

// File: rtl/gf2_quadratic_system_eval.sv
// ----------------------------------------------------------------------------
// gf2_quadratic_system_eval: GF(2) quadratic system evaluator
// Load request: one key word written per cycle while idle, accepted back to back.
// Evaluate request: the packer takes one variable row a cycle, then the row walk
// does one key store read per cycle; one evaluation at a time, next request taken
// on return.
// Reset clears control only; key store contents are undefined until loaded.
// ----------------------------------------------------------------------------
module gf2_quadratic_system_eval import gf2qs_pkg::*; #(
	parameter int NUM_VARS  = 32,
	parameter int NUM_EQS   = 32,
	parameter int ROW_WORDS = 9
) (
	input  logic clk,
	input  logic arst_n,
	gf2qs_req_if.sink   req,
	gf2qs_rsp_if.source rsp
);

	gf2qs_cmd_t cmd;
	gf2qs_sts_t sts;

	gf2qs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gf2qs_dp #(
		.NUM_VARS  (NUM_VARS),
		.NUM_EQS   (NUM_EQS),
		.ROW_WORDS (ROW_WORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.key_addr        (req.key_addr),
		.key_word        (req.key_word),
		.var_bits        (req.var_bits),
		.sts             (sts),
		.equation_values (rsp.equation_values)
	);

endmodule
